// ===== rtl/core/tfn_pkg.sv =====
`default_nettype none
package tfn_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int NFB_DEF        = 14;
    localparam int OUT_BITS       = 16;
    // the largest scaled magnitude sits in [2^29, 2^30)
    localparam int SCALED_BITS    = 30;
    localparam int SCALE_TOP      = SCALED_BITS - 1;
    localparam int SQ_BITS        = 2 * SCALED_BITS;
    localparam int SUM_BITS       = SQ_BITS + 2;
    localparam int ROOT_BITS      = SUM_BITS / 2;

    typedef logic signed [OUT_BITS-1:0] t_norm;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } t_ctl;
endpackage
`default_nettype wire

// ===== rtl/core/tfn_if.sv =====
`default_nettype none
interface tfn_in_if #(parameter int CB = 16);
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tfn_out_if;
    logic                 valid;
    logic                 ready;
    tfn_pkg::t_norm       norm_x, norm_y, norm_z;
    logic                 degenerate;
    modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
    modport sink   (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tfn_sqrt_cell.sv =====
`default_nettype none
module tfn_sqrt_cell #(
    parameter int SUM_W  = 62,
    parameter int ROOT_W = 31,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [SUM_W-1:0]  i_rad,
    input  wire logic [ROOT_W:0]   i_rem,
    input  wire logic [ROOT_W-1:0] i_root,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_vld,
    output logic [SUM_W-1:0]       o_rad,
    output logic [ROOT_W:0]        o_rem,
    output logic [ROOT_W-1:0]      o_root,
    output logic [SIDE_W-1:0]      o_side
);
    logic [ROOT_W+2:0] t;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W:0]   n_rem;
    logic [ROOT_W-1:0] n_root;

    // one result bit per cell: two radicand bits come down each step
    always_comb begin
        t     = {i_rem, i_rad[SUM_W-1 -: 2]};
        trial = {1'b0, i_root, 2'b01};
        if (t >= trial) begin
            n_rem  = (ROOT_W + 1)'(t - trial);
            n_root = {i_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = t[ROOT_W:0];
            n_root = {i_root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
        if (i_en) begin
            o_rad  <= {i_rad[SUM_W-3:0], 2'b00};
            o_rem  <= n_rem;
            o_root <= n_root;
            o_side <= i_side;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/tfn_div_cell.sv =====
`default_nettype none
module tfn_div_cell #(
    parameter int DEN_W = 31,
    parameter int QB    = 15
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_vld,
    input  wire logic [DEN_W-1:0]       i_den,
    input  wire logic [2:0][DEN_W-1:0]  i_rem,
    input  wire logic [2:0][QB-1:0]     i_nq,
    input  wire tfn_pkg::t_ctl          i_ctl,
    output logic                        o_vld,
    output logic [DEN_W-1:0]            o_den,
    output logic [2:0][DEN_W-1:0]       o_rem,
    output logic [2:0][QB-1:0]          o_nq,
    output tfn_pkg::t_ctl               o_ctl
);
    logic [2:0][DEN_W:0]   t;
    logic [2:0][DEN_W-1:0] n_rem;
    logic [2:0][QB-1:0]    n_nq;

    // restoring step on three lanes; nq holds numerator bits on top, quotient below
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t[k] = {i_rem[k], i_nq[k][QB-1]};
            if (t[k] >= {1'b0, i_den}) begin
                n_rem[k] = DEN_W'(t[k] - {1'b0, i_den});
                n_nq[k]  = {i_nq[k][QB-2:0], 1'b1};
            end else begin
                n_rem[k] = t[k][DEN_W-1:0];
                n_nq[k]  = {i_nq[k][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
        if (i_en) begin
            o_den <= i_den;
            o_rem <= n_rem;
            o_nq  <= n_nq;
            o_ctl <= i_ctl;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/triangle_face_normal.sv =====
// Throughput: one triangle per cycle; the whole pipeline advances when the
// output register is empty or its word is taken, otherwise every stage holds.
// The square root is a chain of 31 cells, one root bit each; the divide a chain
// of NORMAL_FRAC_BITS + 1 cells, one quotient bit each, three lanes wide.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
`default_nettype none
module triangle_face_normal #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NFB_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tfn_in_if.sink     i_tri,
    tfn_out_if.source  o_nrm
);
    import tfn_pkg::*;

    localparam int E    = COORD_BITS + 1;
    localparam int P    = 2 * E;
    localparam int X    = P + 1;
    localparam int PSW  = $clog2(X);
    localparam int NFB  = NORMAL_FRAC_BITS;
    localparam int QB   = NFB + 1;
    localparam int NW   = SCALED_BITS + QB;
    localparam int VW   = (QB + 1 > OUT_BITS) ? QB + 1 : OUT_BITS;
    localparam int SIDE = 3 * SCALED_BITS + 4;

    logic adv;
    logic r_ovld;
    assign adv = !r_ovld || o_nrm.ready;
    assign i_tri.ready = adv;

    // stage 1: edges
    logic                r1_vld;
    logic signed [E-1:0] r1_e [6];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_tri.valid;
        end
        if (adv) begin
            r1_e[0] <= E'(i_tri.bx) - E'(i_tri.ax);
            r1_e[1] <= E'(i_tri.by) - E'(i_tri.ay);
            r1_e[2] <= E'(i_tri.bz) - E'(i_tri.az);
            r1_e[3] <= E'(i_tri.cx) - E'(i_tri.ax);
            r1_e[4] <= E'(i_tri.cy) - E'(i_tri.ay);
            r1_e[5] <= E'(i_tri.cz) - E'(i_tri.az);
        end
    end

    // stage 2: six products
    logic                r2_vld;
    logic signed [P-1:0] r2_p [6];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (adv) begin
            r2_vld <= r1_vld;
        end
        if (adv) begin
            r2_p[0] <= r1_e[1] * r1_e[5];
            r2_p[1] <= r1_e[2] * r1_e[4];
            r2_p[2] <= r1_e[2] * r1_e[3];
            r2_p[3] <= r1_e[0] * r1_e[5];
            r2_p[4] <= r1_e[0] * r1_e[4];
            r2_p[5] <= r1_e[1] * r1_e[3];
        end
    end

    // stage 3: cross product as sign and magnitude
    logic signed [X-1:0] n [3];
    logic                r3_vld;
    logic [2:0][X-1:0]   r3_mag;
    t_ctl                r3_ctl;
    always_comb begin
        n[0] = X'(r2_p[0]) - X'(r2_p[1]);
        n[1] = X'(r2_p[2]) - X'(r2_p[3]);
        n[2] = X'(r2_p[4]) - X'(r2_p[5]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (adv) begin
            r3_vld <= r2_vld;
        end
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r3_ctl.neg[k] <= n[k][X-1];
                r3_mag[k]     <= n[k][X-1] ? X'(-n[k]) : X'(n[k]);
            end
            r3_ctl.degen <= (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
        end
    end

    // stage 4: position of the leading one of the largest magnitude
    logic [X-1:0]   or_m;
    logic [PSW-1:0] pos;
    logic           r4_vld;
    logic [2:0][X-1:0] r4_mag;
    t_ctl           r4_ctl;
    logic [PSW-1:0] r4_pos;
    always_comb begin
        or_m = r3_mag[0] | r3_mag[1] | r3_mag[2];
        pos  = '0;
        for (int i = 0; i < X; i++) begin
            if (or_m[i]) begin
                pos = PSW'(i);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (adv) begin
            r4_vld <= r3_vld;
        end
        if (adv) begin
            r4_mag <= r3_mag;
            r4_ctl <= r3_ctl;
            r4_pos <= pos;
        end
    end

    // stage 5: block scaling to leading one at SCALE_TOP
    logic [X+SCALED_BITS-1:0]      wide [3];
    logic [7:0]                    sh_r, sh_l;
    logic                          r5_vld;
    logic [2:0][SCALED_BITS-1:0]   r5_mag;
    t_ctl                          r5_ctl;
    always_comb begin
        sh_r = 8'(r4_pos) - 8'(SCALE_TOP);
        sh_l = 8'(SCALE_TOP) - 8'(r4_pos);
        for (int k = 0; k < 3; k++) begin
            if (32'(r4_pos) > SCALE_TOP) begin
                wide[k] = (X + SCALED_BITS)'(r4_mag[k]) >> sh_r;
            end else begin
                wide[k] = (X + SCALED_BITS)'(r4_mag[k]) << sh_l;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (adv) begin
            r5_vld <= r4_vld;
        end
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r5_mag[k] <= wide[k][SCALED_BITS-1:0];
            end
            r5_ctl <= r4_ctl;
        end
    end

    // stage 6: squares, stage 7: sum
    logic                        r6_vld, r7_vld;
    logic [2:0][SQ_BITS-1:0]     r6_sq;
    logic [2:0][SCALED_BITS-1:0] r6_mag, r7_mag;
    t_ctl                        r6_ctl, r7_ctl;
    logic [SUM_BITS-1:0]         r7_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (adv) begin
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r6_sq[k] <= r5_mag[k] * r5_mag[k];
            end
            r6_mag <= r5_mag;
            r6_ctl <= r5_ctl;
            r7_sum <= SUM_BITS'(r6_sq[0]) + SUM_BITS'(r6_sq[1]) + SUM_BITS'(r6_sq[2]);
            r7_mag <= r6_mag;
            r7_ctl <= r6_ctl;
        end
    end

    // square root chain
    logic                 s_vld  [ROOT_BITS+1];
    logic [SUM_BITS-1:0]  s_rad  [ROOT_BITS+1];
    logic [ROOT_BITS:0]   s_rem  [ROOT_BITS+1];
    logic [ROOT_BITS-1:0] s_root [ROOT_BITS+1];
    logic [SIDE-1:0]      s_side [ROOT_BITS+1];
    assign s_vld[0]  = r7_vld;
    assign s_rad[0]  = r7_sum;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_side[0] = {r7_mag, r7_ctl};

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
        tfn_sqrt_cell #(.SUM_W(SUM_BITS), .ROOT_W(ROOT_BITS), .SIDE_W(SIDE)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_vld  (s_vld[g]),
            .i_rad  (s_rad[g]),
            .i_rem  (s_rem[g]),
            .i_root (s_root[g]),
            .i_side (s_side[g]),
            .o_vld  (s_vld[g+1]),
            .o_rad  (s_rad[g+1]),
            .o_rem  (s_rem[g+1]),
            .o_root (s_root[g+1]),
            .o_side (s_side[g+1])
        );
    end

    // stage 8: numerator with half-length rounding term, split for the divider
    logic [2:0][SCALED_BITS-1:0] q_mag;
    t_ctl                        q_ctl;
    logic [NW-1:0]               num [3];
    logic [ROOT_BITS-1:0]        len;
    logic                        r8_vld;
    logic [ROOT_BITS-1:0]        r8_len;
    logic [2:0][ROOT_BITS-1:0]   r8_rem;
    logic [2:0][QB-1:0]          r8_nq;
    t_ctl                        r8_ctl;
    assign {q_mag, q_ctl} = s_side[ROOT_BITS];
    assign len = s_root[ROOT_BITS];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num[k] = (NW'(q_mag[k]) << NFB) + NW'(len >> 1);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (adv) begin
            r8_vld <= s_vld[ROOT_BITS];
        end
        if (adv) begin
            // a degenerate word has zero length: divide by one to keep it harmless
            r8_len <= q_ctl.degen ? ROOT_BITS'(1) : len;
            for (int k = 0; k < 3; k++) begin
                r8_rem[k] <= ROOT_BITS'(num[k][NW-1:QB]);
                r8_nq[k]  <= num[k][QB-1:0];
            end
            r8_ctl <= q_ctl;
        end
    end

    // divider chain
    logic                      d_vld [QB+1];
    logic [ROOT_BITS-1:0]      d_den [QB+1];
    logic [2:0][ROOT_BITS-1:0] d_rem [QB+1];
    logic [2:0][QB-1:0]        d_nq  [QB+1];
    t_ctl                      d_ctl [QB+1];
    assign d_vld[0] = r8_vld;
    assign d_den[0] = r8_len;
    assign d_rem[0] = r8_rem;
    assign d_nq[0]  = r8_nq;
    assign d_ctl[0] = r8_ctl;

    for (genvar g = 0; g < QB; g++) begin : g_div
        tfn_div_cell #(.DEN_W(ROOT_BITS), .QB(QB)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_vld  (d_vld[g]),
            .i_den  (d_den[g]),
            .i_rem  (d_rem[g]),
            .i_nq   (d_nq[g]),
            .i_ctl  (d_ctl[g]),
            .o_vld  (d_vld[g+1]),
            .o_den  (d_den[g+1]),
            .o_rem  (d_rem[g+1]),
            .o_nq   (d_nq[g+1]),
            .o_ctl  (d_ctl[g+1])
        );
    end

    // output register: clamp to one, apply sign, zero a degenerate word
    logic [QB-1:0] qc  [3];
    logic [VW-1:0] val [3];
    t_norm         r_nx, r_ny, r_nz;
    logic          r_deg;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qc[k]  = (d_nq[QB][k] > QB'(1) << NFB) ? QB'(1) << NFB : d_nq[QB][k];
            val[k] = d_ctl[QB].neg[k] ? VW'(-VW'(qc[k])) : VW'(qc[k]);
            if (d_ctl[QB].degen) begin
                val[k] = '0;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_ovld <= d_vld[QB];
        end
        if (adv) begin
            r_nx  <= val[0][OUT_BITS-1:0];
            r_ny  <= val[1][OUT_BITS-1:0];
            r_nz  <= val[2][OUT_BITS-1:0];
            r_deg <= d_ctl[QB].degen;
        end
    end

    assign o_nrm.valid      = r_ovld;
    assign o_nrm.norm_x     = r_nx;
    assign o_nrm.norm_y     = r_ny;
    assign o_nrm.norm_z     = r_nz;
    assign o_nrm.degenerate = r_deg;
endmodule
`default_nettype wire

// ===== rtl/core/tfn_chk.sv =====
`default_nettype none
module tfn_chk #(
    parameter int NFB = tfn_pkg::NFB_DEF
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_valid,
    input wire logic           i_ready,
    input wire tfn_pkg::t_norm i_nx,
    input wire tfn_pkg::t_norm i_ny,
    input wire tfn_pkg::t_norm i_nz,
    input wire logic           i_deg
);
    import tfn_pkg::*;

    localparam logic signed [OUT_BITS:0] ONE = (OUT_BITS + 1)'(1) << ((NFB > 14) ? 0 : NFB);

    // a held word keeps its valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("output word dropped while stalled");

    // a held word keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable({i_nx, i_ny, i_nz, i_deg}))
        else $error("output word changed while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_deg |-> i_nx == '0 && i_ny == '0 && i_nz == '0)
        else $error("degenerate word with nonzero normal");

    // components of a non-degenerate unit vector stay within plus or minus one (checked for NFB up to 14)
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_deg && NFB <= 14 |->
            $signed({i_nx[OUT_BITS-1], i_nx}) <= ONE && $signed({i_nx[OUT_BITS-1], i_nx}) >= -ONE
            && $signed({i_ny[OUT_BITS-1], i_ny}) <= ONE && $signed({i_ny[OUT_BITS-1], i_ny}) >= -ONE
            && $signed({i_nz[OUT_BITS-1], i_nz}) <= ONE && $signed({i_nz[OUT_BITS-1], i_nz}) >= -ONE)
        else $error("normal component beyond one");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");
endmodule

bind triangle_face_normal tfn_chk #(.NFB(NORMAL_FRAC_BITS)) u_tfn_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(o_nrm.valid),
    .i_ready(o_nrm.ready),
    .i_nx   (o_nrm.norm_x),
    .i_ny   (o_nrm.norm_y),
    .i_nz   (o_nrm.norm_z),
    .i_deg  (o_nrm.degenerate)
);
`default_nettype wire

// ===== sim/triangle_face_normal_tb.sv =====
module triangle_face_normal_tb;
    import tfn_pkg::*;

    localparam int NFB = NFB_DEF;

    typedef struct {
        logic signed [15:0] nx, ny, nz;
        logic               degen;
    } normal_t;

    typedef logic signed [15:0] coord_t;

    // exact integer square root, bit by bit
    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > s) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (s >= res + bit_v) begin
                s = s - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic normal_t face_normal(coord_t v[9]);
        longint e1x, e1y, e1z, e2x, e2y, e2z;
        longint cr[3];
        longint unsigned mag[3], m, sum, len, q;
        logic neg[3];
        normal_t r;
        e1x = v[3] - v[0]; e1y = v[4] - v[1]; e1z = v[5] - v[2];
        e2x = v[6] - v[0]; e2y = v[7] - v[1]; e2z = v[8] - v[2];
        cr[0] = e1y * e2z - e1z * e2y;
        cr[1] = e1z * e2x - e1x * e2z;
        cr[2] = e1x * e2y - e1y * e2x;
        r = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) return r;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = cr[i] < 0;
            mag[i] = neg[i] ? -cr[i] : cr[i];
            if (mag[i] > m) m = mag[i];
        end
        while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << NFB) + (len >> 1)) / len;
            if (q > (64'd1 << NFB)) q = 64'd1 << NFB;
            if (neg[i]) q = -q;
            if (i == 0) r.nx = q[15:0];
            else if (i == 1) r.ny = q[15:0];
            else r.nz = q[15:0];
        end
        r.degen = 1'b0;
        return r;
    endfunction

    class normal_board;
        normal_t pending[$];
        int      errors = 0;

        function void note_triangle(coord_t v[9]);
            pending.insert(pending.size(), face_normal(v));
        endfunction

        function void check_normal(normal_t got);
            normal_t want;
            if (pending.size() == 0) begin
                $error("normal word with nothing outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.nx !== want.nx) begin
                $error("norm_x: expected %0d, got %0d", want.nx, got.nx); errors++;
            end
            if (got.ny !== want.ny) begin
                $error("norm_y: expected %0d, got %0d", want.ny, got.ny); errors++;
            end
            if (got.nz !== want.nz) begin
                $error("norm_z: expected %0d, got %0d", want.nz, got.nz); errors++;
            end
            if (got.degen !== want.degen) begin
                $error("degenerate: expected %0d, got %0d", want.degen, got.degen); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tfn_in_if  tri_if ();
    tfn_out_if nrm_if ();

    triangle_face_normal dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (tri_if.sink),
        .o_nrm  (nrm_if.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    normal_board board = new();
    coord_t  tri_q[$][9];
    bit      sending_done = 1'b0;

    initial begin
        tri_if.valid = 1'b0;
        {tri_if.ax, tri_if.ay, tri_if.az, tri_if.bx, tri_if.by} = '0;
        {tri_if.bz, tri_if.cx, tri_if.cy, tri_if.cz} = '0;
        nrm_if.ready = 1'b0;
    end

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom_range(0, 65535));
            1: return coord_t'($urandom_range(0, 15)) - 16'sd8;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return coord_t'($urandom_range(0, 1023)) - 16'sd512;
        endcase
    endfunction

    task automatic queue_tri(coord_t a0, a1, a2, b0, b1, b2, c0, c1, c2);
        coord_t v[9];
        v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        tri_q.insert(tri_q.size(), v);
    endtask

    task automatic build_stimulus();
        coord_t v[9];
        coord_t mx, mn;
        mx = 16'sh7fff; mn = 16'sh8000;
        queue_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);              // all coincident
        queue_tri(0, 0, 0, 256, 0, 0, 512, 0, 0);          // collinear
        queue_tri(0, 0, 0, 256, 0, 0, 0, 256, 0);          // +z normal
        queue_tri(0, 0, 0, 0, 256, 0, 256, 0, 0);          // -z normal
        queue_tri(0, 0, 0, 0, 256, 0, 0, 0, 256);          // +x
        queue_tri(0, 0, 0, 0, 0, 256, 256, 0, 0);          // +y
        queue_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);              // tiny, scaled up
        queue_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn);     // widest edges
        queue_tri(mx, mx, mx, mn, mn, mn, mn, mx, mx);
        queue_tri(mn, mx, mn, mx, mn, mx, mx, mx, mn);
        queue_tri(0, 0, 0, 1, 1, 1, 1, 0, 1);              // diagonal, rounding
        queue_tri(0, 0, 0, 256, 256, 0, 0, 256, 256);
        queue_tri(-1, -1, -1, -1, -1, -1, 5, 7, 9);        // degenerate, two equal
        queue_tri(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
                  16'shaaaa, 16'sh5555, 16'sh5555, 16'shaaaa);
        queue_tri(mx, 0, 0, 0, mx, 0, 0, 0, mx);
        queue_tri(mn, 0, 0, 0, mn, 0, 0, 0, mn);
        for (int n = 0; n < 950; n++) begin
            int mode;
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 9; k++) v[k] = rand_coord(mode);
            // some collinear or repeated vertices for the degenerate path
            if ($urandom_range(0, 15) == 0) begin
                for (int k = 0; k < 3; k++) v[6+k] = v[3+k];
            end else if ($urandom_range(0, 15) == 0) begin
                for (int k = 0; k < 3; k++) v[6+k] = coord_t'(2*v[3+k] - v[k]);
            end
            tri_q.insert(tri_q.size(), v);
        end
    endtask

    // sender: bursts with random gaps
    initial begin
        coord_t v[9];
        int burst;
        build_stimulus();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (tri_q.size() > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && tri_q.size() > 0) begin
                v = tri_q[0];
                tri_if.valid = 1'b1;
                {tri_if.ax, tri_if.ay, tri_if.az} = {v[0], v[1], v[2]};
                {tri_if.bx, tri_if.by, tri_if.bz} = {v[3], v[4], v[5]};
                {tri_if.cx, tri_if.cy, tri_if.cz} = {v[6], v[7], v[8]};
                @(posedge i_clk);
                while (!tri_if.ready) @(posedge i_clk);
                board.note_triangle(v);
                void'(tri_q.pop_front());
                burst--;
                @(negedge i_clk);
            end
            tri_if.valid = 1'b0;
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        tri_if.valid = 1'b0;
        sending_done = 1'b1;
    end

    // receiver: stall pattern of its own, with calm stretches
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (phase[8]) nrm_if.ready = 1'b1;
            else nrm_if.ready = ($urandom_range(0, 9) < 6) || (phase % 7 == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && nrm_if.valid && nrm_if.ready)
            board.check_normal('{nrm_if.norm_x, nrm_if.norm_y, nrm_if.norm_z,
                                 nrm_if.degenerate});
    end

    initial begin
        wait (sending_done);
        while (board.pending.size() > 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("triangle_face_normal: match");
        else
            $display("triangle_face_normal: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("triangle_face_normal: mismatch");
        $finish;
    end
endmodule
